[sv/ttl_pkg.sv]
package ttl_pkg;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_end;
        logic       input_done;
    } result_t;

    // Byte after classification; is_crlf bytes also set is_blank, and is_end may be set with any other flag.
    typedef struct packed {
        logic [7:0] data;
        logic       is_end;
        logic       is_blank;
        logic       is_hash;
        logic       is_squote;
        logic       is_dquote;
        logic       is_bslash;
        logic       is_crlf;
    } cls_t;

endpackage

[sv/ttl_front.sv]
module ttl_front
    import ttl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item,
    output logic  cls_valid,
    input  logic  cls_ready,
    output cls_t  cls
);

    logic valid_reg;
    logic valid_next;
    cls_t cls_reg;
    cls_t cls_next;

    always_comb
    begin
        cls_next.data      = item.in_byte;
        cls_next.is_end    = item.end_of_input || (item.in_byte == CH_NUL);
        cls_next.is_blank  = (item.in_byte == CH_SPACE) ||
                             ((item.in_byte >= CH_TAB) && (item.in_byte <= CH_CR));
        cls_next.is_hash   = (item.in_byte == CH_HASH);
        cls_next.is_squote = (item.in_byte == CH_SQUOTE);
        cls_next.is_dquote = (item.in_byte == CH_DQUOTE);
        cls_next.is_bslash = (item.in_byte == CH_BSLASH);
        cls_next.is_crlf   = (item.in_byte == CH_CR) || (item.in_byte == CH_LF);
    end

    assign item_ready = !valid_reg || cls_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_valid && item_ready)
        begin
            valid_next = 1'b1;
        end
        else if (cls_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            cls_reg <= cls_next;
        end
    end

    assign cls_valid = valid_reg;
    assign cls       = cls_reg;

endmodule

[sv/ttl_queue.sv]
module ttl_queue
    import ttl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cls_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cls_t pop_data
);

    cls_t                mem [QUEUE_DEPTH];
    cls_t                head_reg;
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != QUEUE_DEPTH[QUEUE_AW:0]);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = head_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        // Prefetch the next head; take the incoming item when it lands there.
        if (push && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= push_data;
        end
        else
        begin
            head_reg <= mem[rd_ptr_next];
        end
    end

endmodule

[sv/ttl_back.sv]
module ttl_back
    import ttl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cls_valid,
    output logic    cls_ready,
    input  cls_t    cls,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    typedef enum logic [1:0] {
        MODE_SKIP,
        MODE_COMMENT,
        MODE_QUOTED,
        MODE_BARE
    } mode_t;

    mode_t   mode_reg;
    mode_t   mode_next;
    logic    esc_reg;
    logic    esc_next;
    logic    dq_reg;
    logic    dq_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    logic    emit;
    result_t res;
    logic    pop;
    logic    close_quote;

    // Advance whenever the output slot is free or being drained this cycle.
    assign cls_ready   = !out_valid_reg || result_ready;
    assign pop         = cls_valid && cls_ready;
    assign close_quote = dq_reg ? cls.is_dquote : cls.is_squote;

    always_comb
    begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        dq_next   = dq_reg;
        emit      = 1'b0;
        res       = '0;
        if (cls.is_end)
        begin
            emit           = 1'b1;
            res.token_end  = (mode_reg == MODE_QUOTED) || (mode_reg == MODE_BARE);
            res.input_done = 1'b1;
            mode_next      = MODE_SKIP;
            esc_next       = 1'b0;
            dq_next        = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_SKIP:
                begin
                    if (cls.is_blank)
                    begin
                        mode_next = MODE_SKIP;
                    end
                    else if (cls.is_hash)
                    begin
                        mode_next = MODE_COMMENT;
                    end
                    else if (cls.is_squote || cls.is_dquote)
                    begin
                        mode_next = MODE_QUOTED;
                        dq_next   = cls.is_dquote;
                        esc_next  = 1'b0;
                    end
                    else
                    begin
                        // first byte of a bare token is always literal
                        mode_next      = MODE_BARE;
                        esc_next       = 1'b0;
                        emit           = 1'b1;
                        res.out_byte   = cls.data;
                        res.byte_valid = 1'b1;
                    end
                end
                MODE_COMMENT:
                begin
                    if (cls.is_crlf)
                    begin
                        mode_next = MODE_SKIP;
                    end
                end
                MODE_QUOTED:
                begin
                    if (esc_reg)
                    begin
                        esc_next       = 1'b0;
                        emit           = 1'b1;
                        res.out_byte   = cls.data;
                        res.byte_valid = 1'b1;
                    end
                    else if (close_quote)
                    begin
                        mode_next     = MODE_SKIP;
                        dq_next       = 1'b0;
                        emit          = 1'b1;
                        res.token_end = 1'b1;
                    end
                    else if (cls.is_bslash)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        emit           = 1'b1;
                        res.out_byte   = cls.data;
                        res.byte_valid = 1'b1;
                    end
                end
                MODE_BARE:
                begin
                    if (esc_reg)
                    begin
                        esc_next       = 1'b0;
                        emit           = 1'b1;
                        res.out_byte   = cls.data;
                        res.byte_valid = 1'b1;
                    end
                    else if (cls.is_blank)
                    begin
                        mode_next     = MODE_SKIP;
                        emit          = 1'b1;
                        res.token_end = 1'b1;
                    end
                    else if (cls.is_bslash)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        emit           = 1'b1;
                        res.out_byte   = cls.data;
                        res.byte_valid = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_SKIP;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = emit;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_SKIP;
            esc_reg       <= 1'b0;
            dq_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                mode_reg <= mode_next;
                esc_reg  <= esc_next;
                dq_reg   <= dq_next;
                if (emit)
                begin
                    out_reg <= res;
                end
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[sv/text_token_lexer.sv]
// Pipeline: an accepted item passes the front register, the queue and the output
//   register; items that give no result are dropped in the back stage.
// Throughput: one item per cycle without output stalls; the 4-entry queue absorbs them.
// Reset: rst_n asynchronous, active low; empties the pipeline and returns the
//   lexer to whitespace skipping with no escape or quote pending.
module text_token_lexer
    import ttl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic front_valid;
    logic front_ready;
    cls_t front_cls;
    logic back_valid;
    logic back_ready;
    cls_t back_cls;

    ttl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cls_valid  (front_valid),
        .cls_ready  (front_ready),
        .cls        (front_cls)
    );

    ttl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cls),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cls)
    );

    ttl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cls_valid    (back_valid),
        .cls_ready    (back_ready),
        .cls          (back_cls),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // A blocked front item must not be lost while the queue is full.
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        front_valid && !front_ready |=> front_valid && $stable(front_cls))
        else $error("front item lost while queue full");

    a_byte_alone: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.byte_valid |-> !result.token_end && !result.input_done)
        else $error("token byte combined with end mark");

    a_mark_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.byte_valid |-> result.out_byte == CH_NUL)
        else $error("end mark carries a nonzero byte");

    a_mark_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.byte_valid |-> result.token_end || result.input_done)
        else $error("result carries nothing");

endmodule

[dv/text_token_lexer_tb.sv]
`timescale 1ns / 100ps

module text_token_lexer_tb;
    import ttl_pkg::*;

    localparam int LONG_HOLD   = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;

    typedef enum logic [1:0] {
        SCAN_SKIP,
        SCAN_COMMENT,
        SCAN_QUOTED,
        SCAN_BARE
    } scan_mode_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    // lexer state mirrored by the predictor
    scan_mode_t lex_mode    = SCAN_SKIP;
    logic       lex_escape  = 1'b0;
    logic       lex_dquote  = 1'b0;

    result_t expected_results[$];
    int      mismatch_count = 0;
    int      items_sent     = 0;
    int      idle_cycles    = 0;

    logic send_idle = 1'b1;
    logic recv_idle = 1'b1;
    int   hold_req  = 0;
    int   hold_ack  = 0;
    int   stall_left = 0;

    text_token_lexer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic make_token_result(output result_t res, input logic [7:0] b,
                                               input logic vld, input logic tend,
                                               input logic done);
        res.out_byte   = b;
        res.byte_valid = vld;
        res.token_end  = tend;
        res.input_done = done;
        return 1'b1;
    endfunction

    // Advance the lexer by one item; returns 1 when the item yields a token result.
    function automatic logic lex_next_token_result(input item_t it, output result_t res);
        logic [7:0] c;
        logic       open_token;
        c = it.in_byte;
        res = '0;
        if (it.end_of_input || c == CH_NUL) begin
            open_token = (lex_mode == SCAN_QUOTED) || (lex_mode == SCAN_BARE);
            lex_mode   = SCAN_SKIP;
            lex_escape = 1'b0;
            lex_dquote = 1'b0;
            return make_token_result(res, 8'h00, 1'b0, open_token, 1'b1);
        end
        case (lex_mode)
            SCAN_SKIP:
            begin
                if (is_blank(c))
                    return 1'b0;
                if (c == CH_HASH) begin
                    lex_mode = SCAN_COMMENT;
                    return 1'b0;
                end
                if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                    lex_mode   = SCAN_QUOTED;
                    lex_dquote = (c == CH_DQUOTE);
                    lex_escape = 1'b0;
                    return 1'b0;
                end
                // first byte of a bare token is literal, backslash included
                lex_mode   = SCAN_BARE;
                lex_escape = 1'b0;
                return make_token_result(res, c, 1'b1, 1'b0, 1'b0);
            end
            SCAN_COMMENT:
            begin
                if (c == CH_CR || c == CH_LF)
                    lex_mode = SCAN_SKIP;
                return 1'b0;
            end
            SCAN_QUOTED:
            begin
                if (lex_escape) begin
                    lex_escape = 1'b0;
                    return make_token_result(res, c, 1'b1, 1'b0, 1'b0);
                end
                if (c == (lex_dquote ? CH_DQUOTE : CH_SQUOTE)) begin
                    lex_mode   = SCAN_SKIP;
                    lex_dquote = 1'b0;
                    return make_token_result(res, 8'h00, 1'b0, 1'b1, 1'b0);
                end
                if (c == CH_BSLASH) begin
                    lex_escape = 1'b1;
                    return 1'b0;
                end
                return make_token_result(res, c, 1'b1, 1'b0, 1'b0);
            end
            default:
            begin
                if (lex_escape) begin
                    lex_escape = 1'b0;
                    return make_token_result(res, c, 1'b1, 1'b0, 1'b0);
                end
                if (is_blank(c)) begin
                    lex_mode = SCAN_SKIP;
                    return make_token_result(res, 8'h00, 1'b0, 1'b1, 1'b0);
                end
                if (c == CH_BSLASH) begin
                    lex_escape = 1'b1;
                    return 1'b0;
                end
                return make_token_result(res, c, 1'b1, 1'b0, 1'b0);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic send_item(input logic [7:0] b, input logic eoi);
        item_t   it;
        result_t res;
        int      gap;
        gap = 0;
        if (send_idle && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.in_byte      = b;
        it.end_of_input = eoi;
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (lex_next_token_result(it, res))
            expected_results.insert(expected_results.size(), res);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0);
    endtask

    // Hold the input idle until every expected result is back.
    task automatic wait_drain();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    function automatic logic [7:0] word_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(33, 255));
        while (b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        return ($urandom_range(0, 2) == 0) ? CH_SPACE : 8'($urandom_range(9, 13));
    endfunction

    task automatic send_bare_word();
        logic [7:0] first;
        int         len;
        if ($urandom_range(0, 7) == 0) begin
            first = CH_BSLASH;
        end else begin
            do
                first = word_byte();
            while (first == CH_HASH || first == CH_SQUOTE || first == CH_DQUOTE);
        end
        send_byte(first);
        len = $urandom_range(0, 6);
        repeat (len) begin
            if ($urandom_range(0, 5) == 0) begin
                send_byte(CH_BSLASH);
                send_byte(8'($urandom_range(1, 255)));
            end else begin
                send_byte(word_byte());
            end
        end
        if ($urandom_range(0, 3) != 0)
            send_byte(blank_byte());
    endtask

    task automatic send_quoted();
        logic [7:0] q;
        int         len;
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        send_byte(q);
        len = $urandom_range(0, 6);
        repeat (len) begin
            if ($urandom_range(0, 5) == 0) begin
                send_byte(CH_BSLASH);
                send_byte(8'($urandom_range(1, 255)));
            end else begin
                send_byte(8'($urandom_range(1, 255)));
            end
        end
        if ($urandom_range(0, 7) != 0)
            send_byte(q);
    endtask

    task automatic send_comment();
        int len;
        send_byte(CH_HASH);
        len = $urandom_range(0, 8);
        repeat (len)
            send_byte(8'($urandom_range(1, 255)));
        send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    endtask

    task automatic send_random_chunk();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 5) begin
            repeat ($urandom_range(1, 3))
                send_byte(blank_byte());
        end else if (pick < 10) begin
            send_bare_word();
        end else if (pick < 14) begin
            send_quoted();
        end else if (pick < 16) begin
            send_comment();
        end else if (pick < 19) begin
            send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else if ($urandom_range(0, 1)) begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            send_byte(CH_NUL);
        end
    endtask

    task automatic test_bare_tokens();
        send_byte(CH_SPACE);
        send_byte("a");
        send_byte(CH_BSLASH);
        send_byte(CH_SPACE);
        send_byte(CH_TAB);
        send_byte(CH_BSLASH);
        send_byte(8'h80);
        send_byte(CH_LF);
    endtask

    task automatic test_comments();
        send_byte(CH_HASH);
        send_byte(CH_SQUOTE);
        send_byte(CH_CR);
        send_byte(CH_HASH);
        send_byte(CH_LF);
    endtask

    task automatic test_quoted_tokens();
        send_byte(CH_DQUOTE);
        send_byte(CH_DQUOTE);
        send_byte(CH_SQUOTE);
        send_byte(CH_DQUOTE);
        send_byte(CH_BSLASH);
        send_byte(CH_SQUOTE);
        send_byte(8'hFF);
        send_byte(CH_SQUOTE);
    endtask

    task automatic test_end_of_input();
        send_byte("z");
        send_item(8'hFF, 1'b1);
        send_byte(CH_DQUOTE);
        send_byte(CH_BSLASH);
        send_byte(CH_NUL);
        send_byte(CH_HASH);
        send_item(8'h00, 1'b1);
    endtask

    // Stall the output long enough to fill the block while items keep coming.
    task automatic test_backpressure();
        send_idle = 1'b0;
        hold_req++;
        repeat (40)
            send_random_chunk();
        wait_drain();
        send_idle = 1'b1;
    endtask

    task automatic test_random_stream(input int target);
        int start;
        int next_switch;
        start = items_sent;
        next_switch = items_sent;
        while (items_sent - start < target) begin
            if (items_sent >= next_switch) begin
                send_idle   = ($urandom_range(0, 2) != 0);
                recv_idle   = ($urandom_range(0, 2) != 0);
                next_switch = items_sent + $urandom_range(30, 80);
            end
            send_random_chunk();
            if ($urandom_range(0, 199) == 0)
                wait_drain();
        end
    endtask

    task automatic test_full_rate(input int target);
        int start;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        start = items_sent;
        while (items_sent - start < target)
            send_random_chunk();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n) begin
            result_ready <= 1'b0;
        end else if (stall_left > 0) begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack     <= hold_req;
            stall_left   <= LONG_HOLD - 1;
            result_ready <= 1'b0;
        end else if (recv_idle && $urandom_range(0, 4) == 0) begin
            result_ready <= 1'b0;
            stall_left   <= $urandom_range(0, 5);
        end else begin
            result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t exp_res;
        if (rst_n && result_valid && result_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", result));
            end else begin
                exp_res = expected_results.pop_front();
                if (result.out_byte !== exp_res.out_byte)
                    report_mismatch($sformatf("out_byte got %02h expected %02h",
                                              result.out_byte, exp_res.out_byte));
                if (result.byte_valid !== exp_res.byte_valid)
                    report_mismatch($sformatf("byte_valid got %b expected %b",
                                              result.byte_valid, exp_res.byte_valid));
                if (result.token_end !== exp_res.token_end)
                    report_mismatch($sformatf("token_end got %b expected %b",
                                              result.token_end, exp_res.token_end));
                if (result.input_done !== exp_res.input_done)
                    report_mismatch($sformatf("input_done got %b expected %b",
                                              result.input_done, exp_res.input_done));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_bare_tokens();
        test_comments();
        test_quoted_tokens();
        test_end_of_input();
        test_backpressure();
        test_random_stream(1000);
        wait_drain();
        test_full_rate(120);
        wait_drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
sv/ttl_pkg.sv
sv/ttl_front.sv
sv/ttl_queue.sv
sv/ttl_back.sv
sv/text_token_lexer.sv
dv/text_token_lexer_tb.sv
